// File: sv/dts_pkg.sv
`timescale 1ns / 1ps
package dts_pkg;

  localparam logic [3:0] MODE_TICK    = 4'd0;
  localparam logic [3:0] MODE_CREATE  = 4'd1;
  localparam logic [3:0] MODE_DELAY   = 4'd2;
  localparam logic [3:0] MODE_ENTER   = 4'd3;
  localparam logic [3:0] MODE_EXIT    = 4'd4;
  localparam logic [3:0] MODE_DELETE  = 4'd5;
  localparam logic [3:0] MODE_SUSPEND = 4'd6;
  localparam logic [3:0] MODE_RESUME  = 4'd7;
  localparam logic [3:0] MODE_QUERY   = 4'd8;

  localparam logic [2:0] ST_RUNNING   = 3'd0;
  localparam logic [2:0] ST_READY     = 3'd1;
  localparam logic [2:0] ST_DELAYED   = 3'd2;
  localparam logic [2:0] ST_SUSPENDED = 3'd3;
  localparam logic [2:0] ST_DEAD      = 3'd4;
  localparam logic [2:0] ST_EMPTY     = 3'd5;

  // real-time key window
  localparam logic [31:0] DEADLINE_OFFSET = 32'(16'hFFFF >> 1);
  // running average keeps 7/8 of the old value
  localparam int unsigned AVG_SHIFT = 3;

  typedef struct packed {
    logic [3:0]  mode;
    logic [3:0]  slot;
    logic [15:0] deadline;
    logic [7:0]  respond;
    logic [15:0] period;
    logic [15:0] delay_ticks;
  } in_item_t;

  typedef struct packed {
    logic [3:0]  running_task;
    logic        idle;
    logic        switched;
    logic [31:0] exec_time;
    logic [31:0] smoothed_time;
    logic        deadline_miss;
    logic [2:0]  task_state;
    logic        status;
    logic [31:0] now;
  } out_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] key;
    logic [15:0] deadline;
    logic [7:0]  respond;
    logic [15:0] period;
    logic [31:0] stamp;
    logic [31:0] average;
  } slot_rec_t;

endpackage

// File: sv/dts_slot_mem.sv
`timescale 1ns / 1ps
module dts_slot_mem #(
  parameter int TASK_SLOTS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [$clog2(TASK_SLOTS)-1:0] rd_addr,
  output dts_pkg::slot_rec_t            rd_data,
  output logic                          rd_vld,
  input  logic                          wr_en,
  input  logic [$clog2(TASK_SLOTS)-1:0] wr_addr,
  input  dts_pkg::slot_rec_t            wr_data
);
  import dts_pkg::*;

  slot_rec_t                 slot_mem_r [TASK_SLOTS];
  slot_rec_t                 rd_data_r;
  logic [TASK_SLOTS-1:0]     vld_r;
  logic                      rd_vld_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slot_mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= slot_mem_r[rd_addr];
  end

  // per-slot valid: an unwritten slot reads as empty
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      rd_vld_r <= vld_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;
  assign rd_vld  = rd_vld_r;

endmodule

// File: sv/dts_engine.sv
`timescale 1ns / 1ps
module dts_engine #(
  parameter int TASK_SLOTS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  dts_pkg::in_item_t             item,
  input  logic                          wake_en,
  output logic                          ready,
  input  logic                          out_free,
  output logic                          done,
  output dts_pkg::out_item_t            result,
  output logic [$clog2(TASK_SLOTS)-1:0] rd_addr,
  input  dts_pkg::slot_rec_t            rd_data,
  input  logic                          rd_vld,
  output logic                          wr_en,
  output logic [$clog2(TASK_SLOTS)-1:0] wr_addr,
  output dts_pkg::slot_rec_t            wr_data
);
  import dts_pkg::*;

  localparam int IW = $clog2(TASK_SLOTS);
  localparam int CW = $clog2(TASK_SLOTS + 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_ISSUE = 3'd1;
  localparam logic [2:0] S_OP    = 3'd2;
  localparam logic [2:0] S_EXIT2 = 3'd3;
  localparam logic [2:0] S_SCAN  = 3'd4;
  localparam logic [2:0] S_DPOST = 3'd5;
  localparam logic [2:0] S_WPOST = 3'd6;
  localparam logic [2:0] S_FIN   = 3'd7;

  function automatic logic key_before(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] d;
    d = a - b;
    return d[31];
  endfunction

  function automatic logic key_before_eq(input logic [31:0] a, input logic [31:0] b);
    return (a == b) || key_before(a, b);
  endfunction

  function automatic logic [31:0] ready_key(input logic [31:0] now,
                                            input logic [15:0] dl,
                                            input logic [7:0]  rsp);
    if (dl != 16'd0) return now + 32'(dl) - DEADLINE_OFFSET;
    return now + 32'(rsp);
  endfunction

  logic [2:0]   st_r, st_nxt;
  in_item_t     item_r, item_nxt;
  logic [31:0]  now_r, now_nxt;
  logic [IW-1:0] cur_r, cur_nxt;
  logic         idle_r, idle_nxt;
  logic [31:0]  cur_key_r, cur_key_nxt;
  logic [IW-1:0] tgt_r, tgt_nxt;
  logic [2:0]   kind_r, kind_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic         found_r, found_nxt;
  logic [IW-1:0] best_r, best_nxt;
  slot_rec_t    best_rec_r, best_rec_nxt;
  slot_rec_t    rec_r, rec_nxt;
  logic [34:0]  t7_r, t7_nxt;
  logic         sw_r, sw_nxt;
  logic [31:0]  exec_r, exec_nxt;
  logic [31:0]  smooth_r, smooth_nxt;
  logic         miss_r, miss_nxt;
  logic [2:0]   tstate_r, tstate_nxt;
  logic         status_r, status_nxt;

  logic         scan_go;
  logic [2:0]   scan_kind;
  logic         slot_ok;
  logic [IW-1:0] in_tgt;
  logic [2:0]   eff_st;
  slot_rec_t    wrec;
  logic [31:0]  nkey;
  logic [IW-1:0] eval_idx;
  logic [34:0]  acc;
  logic [31:0]  avg_new;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= S_IDLE;
      now_r   <= '0;
      cur_r   <= '0;
      idle_r  <= 1'b1;
    end else begin
      st_r    <= st_nxt;
      now_r   <= now_nxt;
      cur_r   <= cur_nxt;
      idle_r  <= idle_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r     <= item_nxt;
    cur_key_r  <= cur_key_nxt;
    tgt_r      <= tgt_nxt;
    kind_r     <= kind_nxt;
    cnt_r      <= cnt_nxt;
    found_r    <= found_nxt;
    best_r     <= best_nxt;
    best_rec_r <= best_rec_nxt;
    rec_r      <= rec_nxt;
    t7_r       <= t7_nxt;
    sw_r       <= sw_nxt;
    exec_r     <= exec_nxt;
    smooth_r   <= smooth_nxt;
    miss_r     <= miss_nxt;
    tstate_r   <= tstate_nxt;
    status_r   <= status_nxt;
  end

  assign slot_ok  = 32'(item.slot) < 32'(TASK_SLOTS);
  assign in_tgt   = IW'(item.slot);
  assign eff_st   = rd_vld ? rd_data.status : ST_EMPTY;
  assign eval_idx = IW'(cnt_r - CW'(1));
  assign acc      = t7_r + 35'(exec_r);
  assign avg_new  = (rec_r.average != 32'd0) ? acc[AVG_SHIFT +: 32] : exec_r;

  always_comb begin
    st_nxt       = st_r;
    item_nxt     = item_r;
    now_nxt      = now_r;
    cur_nxt      = cur_r;
    idle_nxt     = idle_r;
    cur_key_nxt  = cur_key_r;
    tgt_nxt      = tgt_r;
    kind_nxt     = kind_r;
    cnt_nxt      = cnt_r;
    found_nxt    = found_r;
    best_nxt     = best_r;
    best_rec_nxt = best_rec_r;
    rec_nxt      = rec_r;
    t7_nxt       = t7_r;
    sw_nxt       = sw_r;
    exec_nxt     = exec_r;
    smooth_nxt   = smooth_r;
    miss_nxt     = miss_r;
    tstate_nxt   = tstate_r;
    status_nxt   = status_r;
    scan_go      = 1'b0;
    scan_kind    = ST_READY;
    rd_addr      = tgt_r;
    wr_en        = 1'b0;
    wr_addr      = tgt_r;
    wrec         = rd_data;
    nkey         = '0;
    done         = 1'b0;

    unique case (st_r)
      S_IDLE: begin
        if (start) begin
          item_nxt   = item;
          sw_nxt     = 1'b0;
          exec_nxt   = '0;
          smooth_nxt = '0;
          miss_nxt   = 1'b0;
          tstate_nxt = ST_RUNNING;
          status_nxt = 1'b0;
          st_nxt     = S_FIN;
          priority case (item.mode)
            MODE_TICK: begin
              now_nxt = now_r + 32'd1;
              if (wake_en) begin
                scan_go   = 1'b1;
                scan_kind = ST_DELAYED;
              end
            end
            MODE_CREATE, MODE_DELETE, MODE_SUSPEND, MODE_RESUME: begin
              if (!slot_ok) status_nxt = 1'b1;
              else begin
                tgt_nxt = in_tgt;
                st_nxt  = S_ISSUE;
              end
            end
            MODE_QUERY: begin
              if (!slot_ok) begin
                status_nxt = 1'b1;
                tstate_nxt = ST_EMPTY;
              end else if (!idle_r && cur_r == in_tgt) begin
                tstate_nxt = ST_RUNNING;
              end else begin
                tgt_nxt = in_tgt;
                st_nxt  = S_ISSUE;
              end
            end
            MODE_DELAY: begin
              if (item.delay_ticks == 16'd0) begin
                st_nxt = S_FIN;
              end else if (idle_r) begin
                status_nxt = 1'b1;
              end else begin
                tgt_nxt = cur_r;
                st_nxt  = S_ISSUE;
              end
            end
            MODE_ENTER, MODE_EXIT: begin
              if (idle_r) status_nxt = 1'b1;
              else begin
                tgt_nxt = cur_r;
                st_nxt  = S_ISSUE;
              end
            end
            default: st_nxt = S_FIN;
          endcase
        end
      end

      S_ISSUE: st_nxt = S_OP;

      S_OP: begin
        st_nxt = S_FIN;
        priority case (item_r.mode)
          MODE_CREATE: begin
            if (eff_st != ST_EMPTY && eff_st != ST_DEAD) status_nxt = 1'b1;
            else begin
              nkey          = ready_key(now_r, item_r.deadline, item_r.respond);
              wrec.status   = ST_READY;
              wrec.key      = nkey;
              wrec.deadline = item_r.deadline;
              wrec.respond  = item_r.respond;
              wrec.period   = item_r.period;
              wrec.average  = '0;
              wr_en         = 1'b1;
              if (idle_r || key_before_eq(nkey, cur_key_r)) begin
                sw_nxt  = 1'b1;
                scan_go = 1'b1;
              end
            end
          end
          MODE_RESUME: begin
            if (eff_st != ST_SUSPENDED) status_nxt = 1'b1;
            else begin
              nkey        = ready_key(now_r, rd_data.deadline, rd_data.respond);
              wrec.status = ST_READY;
              wrec.key    = nkey;
              wr_en       = 1'b1;
              if (idle_r || key_before_eq(nkey, cur_key_r)) begin
                sw_nxt  = 1'b1;
                scan_go = 1'b1;
              end
            end
          end
          MODE_DELAY: begin
            wrec.status = ST_DELAYED;
            wrec.key    = now_r + 32'(item_r.delay_ticks);
            wr_en       = 1'b1;
            sw_nxt      = 1'b1;
            scan_go     = 1'b1;
          end
          MODE_ENTER: begin
            wrec.stamp = now_r;
            wr_en      = 1'b1;
          end
          MODE_EXIT: begin
            rec_nxt  = rd_data;
            exec_nxt = now_r - rd_data.stamp;
            t7_nxt   = {rd_data.average, 3'b000} - 35'(rd_data.average);
            st_nxt   = S_EXIT2;
          end
          MODE_DELETE: begin
            if (eff_st == ST_EMPTY || eff_st == ST_DEAD) status_nxt = 1'b1;
            else begin
              wrec.status = ST_DEAD;
              wr_en       = 1'b1;
              sw_nxt      = 1'b1;
              scan_go     = 1'b1;
            end
          end
          MODE_SUSPEND: begin
            if (eff_st != ST_READY && eff_st != ST_DELAYED) status_nxt = 1'b1;
            else begin
              wrec.status = ST_SUSPENDED;
              wr_en       = 1'b1;
              if (!idle_r && cur_r == tgt_r) begin
                sw_nxt  = 1'b1;
                scan_go = 1'b1;
              end
            end
          end
          MODE_QUERY: tstate_nxt = eff_st;
          default: st_nxt = S_FIN;
        endcase
      end

      S_EXIT2: begin
        smooth_nxt   = avg_new;
        miss_nxt     = (rec_r.deadline != 16'd0) && (exec_r >= 32'(rec_r.deadline));
        wrec         = rec_r;
        wrec.average = avg_new;
        wr_en        = 1'b1;
        st_nxt       = S_FIN;
        if (rec_r.period != 16'd0) begin
          wrec.status = ST_DELAYED;
          wrec.key    = now_r + 32'(rec_r.period);
          sw_nxt      = 1'b1;
          scan_go     = 1'b1;
        end
      end

      S_SCAN: begin
        rd_addr = IW'(cnt_r);
        if (cnt_r != CW'(0)) begin
          if (eff_st == kind_r && (!found_r || key_before(rd_data.key, best_rec_r.key)))
          begin
            found_nxt    = 1'b1;
            best_nxt     = eval_idx;
            best_rec_nxt = rd_data;
          end
        end
        if (cnt_r == CW'(TASK_SLOTS)) begin
          st_nxt = (kind_r == ST_READY) ? S_DPOST : S_WPOST;
        end else begin
          cnt_nxt = cnt_r + CW'(1);
        end
      end

      S_DPOST: begin
        if (found_r) begin
          cur_nxt     = best_r;
          idle_nxt    = 1'b0;
          cur_key_nxt = best_rec_r.key;
        end else begin
          cur_nxt  = '0;
          idle_nxt = 1'b1;
        end
        st_nxt = S_FIN;
        if (item_r.mode == MODE_TICK) begin
          scan_go   = 1'b1;
          scan_kind = ST_DELAYED;
        end
      end

      S_WPOST: begin
        st_nxt = S_FIN;
        if (found_r && key_before_eq(best_rec_r.key, now_r)) begin
          nkey        = ready_key(now_r, best_rec_r.deadline, best_rec_r.respond);
          wrec        = best_rec_r;
          wrec.status = ST_READY;
          wrec.key    = nkey;
          wr_addr     = best_r;
          wr_en       = 1'b1;
          scan_go     = 1'b1;
          if (idle_r || key_before_eq(nkey, cur_key_r)) begin
            sw_nxt    = 1'b1;
            scan_kind = ST_READY;
          end else begin
            scan_kind = ST_DELAYED;
          end
        end
      end

      S_FIN: begin
        if (out_free) begin
          done   = 1'b1;
          st_nxt = S_IDLE;
        end
      end

      default: st_nxt = S_IDLE;
    endcase

    if (scan_go) begin
      kind_nxt  = scan_kind;
      cnt_nxt   = '0;
      found_nxt = 1'b0;
      st_nxt    = S_SCAN;
    end
  end

  assign wr_data = wrec;
  assign ready   = (st_r == S_IDLE);

  always_comb begin
    result.running_task  = idle_r ? 4'd0 : 4'(cur_r);
    result.idle          = idle_r;
    result.switched      = sw_r;
    result.exec_time     = exec_r;
    result.smoothed_time = smooth_r;
    result.deadline_miss = miss_r;
    result.task_state    = tstate_r;
    result.status        = status_r;
    result.now           = now_r;
  end

endmodule

// File: sv/deadline_task_scheduler_core.sv
`timescale 1ns / 1ps
// Channel   Ports                          Moves
// input     in_valid, in_stall, in_data    one scheduler command per transfer
// result    out_valid, out_stall, out_data one result per command
// config    cfg_we, cfg_wdata              wake_enable, written on cfg_we
//
// Commands: one at a time. A scan of the slot table reads every slot through
// the slot memory read port. Tick: a scan of the delayed tasks when wake is
// enabled, again per woken task, plus a ready scan per switch. Create, delete,
// suspend, resume, delay, exit with a switch: a ready scan; others: no scan.
// Reset: synchronous, rst_n low; all slots read empty, idle runs, time zero.
// Stalls: a finished result waits in the output register while the next
// command is already taken in and worked on.
module deadline_task_scheduler_core #(
  parameter int TASK_SLOTS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  dts_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output dts_pkg::out_item_t  out_data,
  input  logic                cfg_we,
  input  logic                cfg_wdata
);
  import dts_pkg::*;

  localparam int IW = $clog2(TASK_SLOTS);

  logic          wake_en_r;
  logic          out_valid_r;
  out_item_t     out_data_r;

  logic          eng_ready;
  logic          eng_done;
  logic          out_free;
  out_item_t     eng_result;
  logic [IW-1:0] rd_addr;
  slot_rec_t     rd_data;
  logic          rd_vld;
  logic          wr_en;
  logic [IW-1:0] wr_addr;
  slot_rec_t     wr_data;

  // config register; the user must write it only between commands, the block does not enforce it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wake_en_r <= 1'b1;
    end else if (cfg_we) begin
      wake_en_r <= cfg_wdata;
    end
  end

  // result can load when the register is empty or draining this cycle
  assign out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (eng_done) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (eng_done) begin
      out_data_r <= eng_result;
    end
  end

  dts_engine #(
    .TASK_SLOTS(TASK_SLOTS)
  ) u_engine (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (in_valid),
    .item     (in_data),
    .wake_en  (wake_en_r),
    .ready    (eng_ready),
    .out_free (out_free),
    .done     (eng_done),
    .result   (eng_result),
    .rd_addr  (rd_addr),
    .rd_data  (rd_data),
    .rd_vld   (rd_vld),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data)
  );

  // slot table: status, key and per-task records
  dts_slot_mem #(
    .TASK_SLOTS(TASK_SLOTS)
  ) u_slot_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .rd_vld  (rd_vld),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  assign in_stall  = !eng_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
